// ===== rtl/core/i2cme_pkg.sv =====
// i2cme_pkg: shared types and constants of the i2c master byte engine
// phase codes, command codes, beat payload structs and register reset values
// no dependencies
`default_nettype none

package i2cme_pkg;

    // bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_START_C  = 4'd3,
        PH_STOP_A   = 4'd4,
        PH_STOP_B   = 4'd5,
        PH_STOP_C   = 4'd6,
        PH_WR_LOW   = 4'd7,
        PH_WR_HIGH  = 4'd8,
        PH_ACK_LOW  = 4'd9,
        PH_ACK_HIGH = 4'd10,
        PH_END_LOW  = 4'd11,
        PH_RD_LOW   = 4'd12,
        PH_RD_HIGH  = 4'd13,
        PH_RA_LOW   = 4'd14,
        PH_RA_HIGH  = 4'd15
    } phase_t;

    // command codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_WRITE     = 3'd3;
    localparam logic [2:0] ACT_READ_ACK  = 3'd4;
    localparam logic [2:0] ACT_READ_NACK = 3'd5;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    // register reset values
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // one input beat
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       sda_in;
    } item_t;

    // one result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cme_if.sv =====
// i2cme channel interfaces: input beat, result beat and configuration write
// depends on i2cme_pkg for the configuration index width
`default_nettype none

interface i2cme_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output action, output tx_byte, output sda_in,
                    input ready);
    modport sink (input valid, input action, input tx_byte, input sda_in,
                  output ready);
endinterface

interface i2cme_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;

    modport source (output valid, output scl_out, output sda_out, output sda_drive,
                    output busy_res, output done_res, output rx_byte,
                    output ack_error, input ready);
    modport sink (input valid, input scl_out, input sda_out, input sda_drive,
                  input busy_res, input done_res, input rx_byte, input ack_error,
                  output ready);
endinterface

interface i2cme_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [i2cme_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/i2cme_seq.sv =====
// i2cme_seq: bus phase sequencer, one tick per accepted beat
// holds the engine state and forms the result of the beat combinationally
// depends on i2cme_pkg
`default_nettype none

module i2cme_seq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  i2cme_pkg::item_t     item,
    input  wire  [7:0]           half_period,
    input  wire  [7:0]           ack_timeout,
    output i2cme_pkg::result_t   result
);

    i2cme_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] wait_reg, wait_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drv_reg, drv_next;
    logic [7:0] rx_reg, rx_next;
    logic       err_reg, err_next;
    logic       nack_reg, nack_next;

    logic              done;
    logic              ent;
    i2cme_pkg::phase_t ent_phase;
    logic [7:0]        hp;
    logic [3:0]        bit_inc;

    // zero half period counts as one tick
    assign hp      = (half_period == 8'd0) ? 8'd1 : half_period;
    assign bit_inc = bit_reg + 4'd1;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cme_pkg::PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            wait_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            rx_reg    <= '0;
            err_reg   <= 1'b0;
            nack_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            wait_reg  <= wait_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            rx_reg    <= rx_next;
            err_reg   <= err_next;
            nack_reg  <= nack_next;
        end
    end

    // next state of one tick
    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        wait_next  = wait_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        rx_next    = rx_reg;
        err_next   = err_reg;
        nack_next  = nack_reg;
        done       = 1'b0;
        ent        = 1'b0;
        ent_phase  = i2cme_pkg::PH_IDLE;

        if (phase_reg == i2cme_pkg::PH_IDLE)
        begin
            // idle: take a new command
            bit_next  = '0;
            wait_next = '0;
            case (item.action)
                i2cme_pkg::ACT_START:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_START_A;
                end
                i2cme_pkg::ACT_STOP:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_STOP_A;
                end
                i2cme_pkg::ACT_WRITE:
                begin
                    shift_next = item.tx_byte;
                    err_next   = 1'b0;
                    ent        = 1'b1;
                    ent_phase  = i2cme_pkg::PH_WR_LOW;
                end
                i2cme_pkg::ACT_READ_ACK, i2cme_pkg::ACT_READ_NACK:
                begin
                    shift_next = '0;
                    nack_next  = (item.action == i2cme_pkg::ACT_READ_NACK);
                    ent        = 1'b1;
                    ent_phase  = i2cme_pkg::PH_RD_LOW;
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == i2cme_pkg::PH_ACK_HIGH && item.sda_in)
        begin
            // waiting for the slave to pull sda low
            if (wait_reg >= ack_timeout)
            begin
                err_next  = 1'b1;
                ent       = 1'b1;
                ent_phase = i2cme_pkg::PH_STOP_A;
            end
            else
            begin
                wait_next = wait_reg + 8'd1;
                if (tick_reg < hp)
                begin
                    tick_next = tick_reg + 8'd1;
                end
            end
        end
        else if (tick_reg >= hp)
        begin
            // half period over: move to the following phase
            case (phase_reg)
                i2cme_pkg::PH_START_A:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_START_B;
                end
                i2cme_pkg::PH_START_B:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_START_C;
                end
                i2cme_pkg::PH_STOP_A:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_STOP_B;
                end
                i2cme_pkg::PH_STOP_B:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_STOP_C;
                end
                i2cme_pkg::PH_WR_LOW:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_WR_HIGH;
                end
                i2cme_pkg::PH_WR_HIGH:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    ent        = 1'b1;
                    ent_phase  = (bit_inc >= i2cme_pkg::BYTE_BITS) ?
                                 i2cme_pkg::PH_ACK_LOW : i2cme_pkg::PH_WR_LOW;
                end
                i2cme_pkg::PH_ACK_LOW:
                begin
                    wait_next = '0;
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_ACK_HIGH;
                end
                i2cme_pkg::PH_ACK_HIGH:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_END_LOW;
                end
                i2cme_pkg::PH_RD_LOW:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_RD_HIGH;
                end
                i2cme_pkg::PH_RD_HIGH:
                begin
                    ent = 1'b1;
                    if (bit_reg >= i2cme_pkg::BYTE_BITS)
                    begin
                        rx_next   = shift_reg;
                        ent_phase = i2cme_pkg::PH_RA_LOW;
                    end
                    else
                    begin
                        ent_phase = i2cme_pkg::PH_RD_LOW;
                    end
                end
                i2cme_pkg::PH_RA_LOW:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_RA_HIGH;
                end
                i2cme_pkg::PH_RA_HIGH:
                begin
                    ent       = 1'b1;
                    ent_phase = i2cme_pkg::PH_END_LOW;
                end
                default:
                begin
                    // last phase of a command: back to idle
                    phase_next = i2cme_pkg::PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                end
            endcase
        end
        else
        begin
            tick_next = tick_reg + 8'd1;
        end

        // phase entry: restart the tick count and set the line levels
        if (ent)
        begin
            phase_next = ent_phase;
            tick_next  = 8'd1;
            case (ent_phase)
                i2cme_pkg::PH_START_A, i2cme_pkg::PH_STOP_C:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b1;
                end
                i2cme_pkg::PH_START_B, i2cme_pkg::PH_STOP_B:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                end
                i2cme_pkg::PH_START_C, i2cme_pkg::PH_STOP_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                end
                i2cme_pkg::PH_WR_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[7];
                    drv_next = 1'b1;
                end
                i2cme_pkg::PH_WR_HIGH, i2cme_pkg::PH_RA_HIGH:
                begin
                    scl_next = 1'b1;
                end
                i2cme_pkg::PH_ACK_LOW, i2cme_pkg::PH_END_LOW, i2cme_pkg::PH_RD_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                end
                i2cme_pkg::PH_ACK_HIGH, i2cme_pkg::PH_RD_HIGH:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b0;
                end
                i2cme_pkg::PH_RA_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = nack_next;
                    drv_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // read sample on the last tick of the scl high half
        if (phase_next == i2cme_pkg::PH_RD_HIGH && tick_next == hp &&
            bit_next < i2cme_pkg::BYTE_BITS)
        begin
            shift_next = {shift_next[6:0], item.sda_in};
            bit_next   = bit_next + 4'd1;
        end
    end

    // result of the beat
    always_comb
    begin
        result.scl_out   = scl_next;
        result.sda_out   = drv_next ? sda_next : 1'b1;
        result.sda_drive = drv_next;
        result.busy_res  = (phase_next != i2cme_pkg::PH_IDLE);
        result.done_res  = done;
        result.rx_byte   = rx_next;
        result.ack_error = err_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2cme_obuf.sv =====
// i2cme_obuf: result register with a skid stage behind it
// keeps the input side open while a result waits downstream
// depends on i2cme_pkg
`default_nettype none

module i2cme_obuf (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                load,
    input  i2cme_pkg::result_t load_data,
    output logic               can_load,
    output logic               out_valid,
    input  wire                out_ready,
    output i2cme_pkg::result_t out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    i2cme_pkg::result_t out_data_reg;
    i2cme_pkg::result_t skid_data_reg;
    logic               take;

    assign take      = out_valid_reg & out_ready;
    assign can_load  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (load && out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end

            if (load || (take && skid_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load && (!out_valid_reg || take))
        begin
            out_data_reg <= load_data;
        end

        if (load && out_valid_reg && !take)
        begin
            skid_data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_byte_engine_unit.sv =====
// i2c_master_byte_engine_unit: top level of the i2c master byte engine
// depends on i2cme_pkg, i2cme_if, i2cme_seq and i2cme_obuf
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------------
//   in_ch   | in  | action, tx_byte, sda_in: one bus tick
//   out_ch  | out | scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
//           |     | ack_error: line levels and status after the tick
//   cfg     | in  | index, data: register write, always ready
//
// one beat per cycle while in_ch is ready: a tick's result is formed combinationally
// and registered on acceptance, in the output register or the skid stage behind it
// the phase sequencer is the single loop: state updates once per accepted beat
// a result register plus a skid stage keep in_ch ready for one stalled beat;
// in_ch.ready drops only while both hold results
// reset clears the state to idle with scl and sda driven high, registers to 5 and 250
`default_nettype none

module i2c_master_byte_engine_unit (
    input  wire          clk,
    input  wire          rst_n,
    i2cme_in_if.sink     in_ch,
    i2cme_out_if.source  out_ch,
    i2cme_cfg_if.sink    cfg
);

    logic [7:0]         half_period_reg;
    logic [7:0]         ack_timeout_reg;
    logic               accept;
    logic               can_load;
    i2cme_pkg::item_t   item;
    i2cme_pkg::result_t result;
    i2cme_pkg::result_t out_data;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cme_pkg::HALF_PERIOD_RESET;
            ack_timeout_reg <= i2cme_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                i2cme_pkg::REG_HALF_PERIOD: half_period_reg <= cfg.data;
                i2cme_pkg::REG_ACK_TIMEOUT: ack_timeout_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // input beat
    assign in_ch.ready  = can_load;
    assign accept       = in_ch.valid & can_load;
    assign item.action  = in_ch.action;
    assign item.tx_byte = in_ch.tx_byte;
    assign item.sda_in  = in_ch.sda_in;

    i2cme_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .half_period (half_period_reg),
        .ack_timeout (ack_timeout_reg),
        .result      (result)
    );

    i2cme_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .can_load  (can_load),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    // result beat
    assign out_ch.scl_out   = out_data.scl_out;
    assign out_ch.sda_out   = out_data.sda_out;
    assign out_ch.sda_drive = out_data.sda_drive;
    assign out_ch.busy_res  = out_data.busy_res;
    assign out_ch.done_res  = out_data.done_res;
    assign out_ch.rx_byte   = out_data.rx_byte;
    assign out_ch.ack_error = out_data.ack_error;

endmodule

`default_nettype wire

// ===== rtl/core/i2cme_checker.sv =====
// i2cme_checker: port-level checks of the i2c master byte engine
// bound to i2c_master_byte_engine_unit; depends on its channel ports only
`default_nettype none

module i2cme_checker (
    input wire clk,
    input wire rst_n,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready,
    input wire out_sda_out,
    input wire out_sda_drive,
    input wire out_busy,
    input wire out_done
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // input side closes only when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // released sda reads as high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_sda_drive |-> out_sda_out)
        else $error("sda_out low while sda released");

    // completion leaves the engine idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_done |-> !out_busy)
        else $error("done pulse while still busy");

endmodule

bind i2c_master_byte_engine_unit i2cme_checker u_i2cme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_sda_out   (out_ch.sda_out),
    .out_sda_drive (out_ch.sda_drive),
    .out_busy      (out_ch.busy_res),
    .out_done      (out_ch.done_res)
);

`default_nettype wire
